>>> design/multicam_ground_color_classifier_macros.svh
// Assertion macros for the ground color classifier.
`ifndef MULTICAM_GROUND_COLOR_CLASSIFIER_MACROS_SVH
`define MULTICAM_GROUND_COLOR_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define MGC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MGC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MGC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> design/mgcc_pkg.sv
// Shared types and constants for the ground color classifier.
package mgcc_pkg;
    localparam int NUM_CAMS  = 8;
    localparam int NUM_PAIRS = NUM_CAMS * (NUM_CAMS - 1) / 2;

    localparam logic [2:0] REG_MATCH  = 3'd0;
    localparam logic [2:0] REG_LIGHT  = 3'd1;
    localparam logic [2:0] REG_WHITE  = 3'd2;
    localparam logic [2:0] REG_COUNT  = 3'd3;
    localparam logic [2:0] REG_ENC    = 3'd4;
    localparam logic [2:0] REG_FLOOR  = 3'd5;

    localparam logic [1:0] ENC_RGB  = 2'd0;
    localparam logic [1:0] ENC_BGR  = 2'd1;
    localparam logic [1:0] ENC_MONO = 2'd2;

    localparam logic [1:0] CLS_NONE     = 2'd0;
    localparam logic [1:0] CLS_GROUND   = 2'd1;
    localparam logic [1:0] CLS_OBSTACLE = 2'd2;
    localparam logic [1:0] CLS_WHITE    = 2'd3;

    typedef logic [NUM_CAMS-1:0][23:0] pix_arr_t;

    typedef struct packed {
        logic [17:0] match_th;
        logic [7:0]  light_th;
        logic [7:0]  white_th;
        logic [3:0]  cam_count;
        logic [15:0] enc;
        logic [3:0]  hit_floor;
    } cfg_t;

    // Pair index p of (i,j), i<j, j*(j-1)/2 + i.
    function automatic logic [2:0] pair_lo(input int p);
        int n;
        n = 0;
        for (int j = 1; j < NUM_CAMS; j++)
            for (int i = 0; i < j; i++) begin
                if (n == p) return 3'(i);
                n++;
            end
        return 3'd0;
    endfunction

    function automatic logic [2:0] pair_hi(input int p);
        int n;
        n = 0;
        for (int j = 1; j < NUM_CAMS; j++)
            for (int i = 0; i < j; i++) begin
                if (n == p) return 3'(j);
                n++;
            end
        return 3'd0;
    endfunction

    function automatic logic [23:0] decode(input logic [23:0] px, input logic [1:0] enc);
        logic [23:0] res;
        res = '0;
        case (enc)
            ENC_RGB:  res = px;
            ENC_BGR:  res = {px[7:0], px[15:8], px[23:16]};
            ENC_MONO: res = {px[7:0], px[7:0], px[7:0]};
            default:  res = '0;
        endcase
        return res;
    endfunction
endpackage

>>> design/mgcc_pair_lane.sv
// One pair lane: squared distance compare of two camera samples.
module mgcc_pair_lane
    import mgcc_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [23:0] px_a,
    input  logic [23:0] px_b,
    input  logic [17:0] match_th,
    output logic        hit
);
    logic [7:0]  d0, d1, d2;
    logic [17:0] sum;
    logic        hit_reg;

    always_comb begin
        d0 = (px_a[7:0] > px_b[7:0]) ? px_a[7:0] - px_b[7:0] : px_b[7:0] - px_a[7:0];
        d1 = (px_a[15:8] > px_b[15:8]) ? px_a[15:8] - px_b[15:8]
                                       : px_b[15:8] - px_a[15:8];
        d2 = (px_a[23:16] > px_b[23:16]) ? px_a[23:16] - px_b[23:16]
                                         : px_b[23:16] - px_a[23:16];
        sum = 18'(16'(d0) * 16'(d0)) + 18'(16'(d1) * 16'(d1)) + 18'(16'(d2) * 16'(d2));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= sum < match_th;
        end
    end

    assign hit = hit_reg;
endmodule

>>> design/mgcc_merge.sv
// Merge stage: pick first matching pair, average color, classify.
module mgcc_merge
    import mgcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NUM_PAIRS-1:0] pair_hit,
    input  logic [NUM_CAMS-1:0]  mask,
    input  pix_arr_t             px,
    input  cfg_t                 cfg,
    output logic [1:0]           point_class,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);
    logic        found;
    logic [2:0]  sel_a, sel_b;
    logic [23:0] ca, cb;
    logic [7:0]  r, g, b;
    logic [3:0]  hits;
    logic        found_reg, obst_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [9:0]  tot;
    logic [7:0]  mean;
    logic [7:0]  dr, dg, db;

    always_comb begin
        found = 1'b0;
        sel_a = '0;
        sel_b = '0;
        for (int p = 0; p < NUM_PAIRS; p++) begin
            if (!found && pair_hit[p]) begin
                found = 1'b1;
                sel_a = pair_lo(p);
                sel_b = pair_hi(p);
            end
        end
        hits = '0;
        for (int k = 0; k < NUM_CAMS; k++)
            hits = hits + 4'(mask[k]);
        ca = decode(px[sel_a], cfg.enc[2*sel_a +: 2]);
        cb = decode(px[sel_b], cfg.enc[2*sel_b +: 2]);
        r = 8'((9'(ca[7:0]) + 9'(cb[7:0])) >> 1);
        g = 8'((9'(ca[15:8]) + 9'(cb[15:8])) >> 1);
        b = 8'((9'(ca[23:16]) + 9'(cb[23:16])) >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            found_reg <= found;
            obst_reg  <= hits > cfg.hit_floor;
            r_reg     <= found ? r : '0;
            g_reg     <= found ? g : '0;
            b_reg     <= found ? b : '0;
        end
    end

    always_comb begin
        tot  = 10'(r_reg) + 10'(g_reg) + 10'(b_reg);
        // divide by three: multiply by 683 and drop 11 bits, exact for sums below 2048
        mean = 8'((20'(tot) * 20'd683) >> 11);
        dr = (r_reg > mean) ? r_reg - mean : mean - r_reg;
        dg = (g_reg > mean) ? g_reg - mean : mean - g_reg;
        db = (b_reg > mean) ? b_reg - mean : mean - b_reg;
        if (found_reg) begin
            if (mean > cfg.light_th && dr < cfg.white_th && dg < cfg.white_th
                && db < cfg.white_th)
                point_class = CLS_WHITE;
            else
                point_class = CLS_GROUND;
        end else if (obst_reg) begin
            point_class = CLS_OBSTACLE;
        end else begin
            point_class = CLS_NONE;
        end
    end

    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;
endmodule

>>> design/multicam_ground_color_classifier.sv
// Ground color classifier: one grid point per cycle through pair lanes and a merge stage.
// One beat is taken every cycle unless the output is held. Stage one registers the beat,
// stage two holds the 28 parallel pair-distance lanes, stage three is the merge that picks
// the earliest matching pair, averages its decoded color and classifies; the result register
// feeds the output. A global enable stalls all stages together when the output is held.
`include "multicam_ground_color_classifier_macros.svh"
module multicam_ground_color_classifier
    import mgcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_hit_mask,
    input  logic [23:0] s_pixel_0,
    input  logic [23:0] s_pixel_1,
    input  logic [23:0] s_pixel_2,
    input  logic [23:0] s_pixel_3,
    input  logic [23:0] s_pixel_4,
    input  logic [23:0] s_pixel_5,
    input  logic [23:0] s_pixel_6,
    input  logic [23:0] s_pixel_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_point_class,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue
);
    cfg_t                cfg_reg;
    logic [2:0]          vld_reg;
    logic                en;
    logic [NUM_CAMS-1:0] mask0_reg, mask1_reg;
    pix_arr_t            px0_reg, px1_reg;
    logic [NUM_PAIRS-1:0] pair_hit;
    logic [3:0]          used;
    logic [NUM_CAMS-1:0] in_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{match_th: 18'd10, light_th: 8'd180, white_th: 8'd10,
                         cam_count: 4'd2, enc: 16'd0, hit_floor: 4'd2};
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MATCH: cfg_reg.match_th  <= cfg_data;
                REG_LIGHT: cfg_reg.light_th  <= cfg_data[7:0];
                REG_WHITE: cfg_reg.white_th  <= cfg_data[7:0];
                REG_COUNT: cfg_reg.cam_count <= cfg_data[3:0];
                REG_ENC:   cfg_reg.enc       <= cfg_data[15:0];
                REG_FLOOR: cfg_reg.hit_floor <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[2];
    assign used    = (cfg_reg.cam_count > 4'(NUM_CAMS)) ? 4'(NUM_CAMS) : cfg_reg.cam_count;

    always_comb begin
        for (int k = 0; k < NUM_CAMS; k++)
            in_mask[k] = s_hit_mask[k] && (4'(k) < used);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mask0_reg <= in_mask;
            px0_reg   <= {s_pixel_7, s_pixel_6, s_pixel_5, s_pixel_4,
                          s_pixel_3, s_pixel_2, s_pixel_1, s_pixel_0};
            mask1_reg <= mask0_reg;
            px1_reg   <= px0_reg;
        end
    end

    logic [NUM_PAIRS-1:0] lane_hit;
    logic [NUM_PAIRS-1:0] pv_reg;

    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_lane
        mgcc_pair_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .px_a     (px0_reg[pair_lo(p)]),
            .px_b     (px0_reg[pair_hi(p)]),
            .match_th (cfg_reg.match_th),
            .hit      (lane_hit[p])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                pv_reg[p] <= mask0_reg[pair_lo(p)] && mask0_reg[pair_hi(p)];
            end
        end
        assign pair_hit[p] = lane_hit[p] && pv_reg[p];
    end

    mgcc_merge u_merge (
        .aclk        (aclk),
        .en          (en),
        .pair_hit    (pair_hit),
        .mask        (mask1_reg),
        .px          (px1_reg),
        .cfg         (cfg_reg),
        .point_class (m_point_class),
        .red         (m_red),
        .green       (m_green),
        .blue        (m_blue)
    );

    `MGC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `MGC_ASSERT_IMP(a_ready, aclk, aresetn, !m_valid, s_ready)
    `MGC_ASSERT_IMP(a_color, aclk, aresetn, m_valid && m_point_class == CLS_OBSTACLE,
                    m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0)
endmodule
